### rtl/cle_pkg.sv
// ----------------------------------------------------------------------------
// cle_pkg: shared types and constants of the console line editor
// Character codes, the SDRAM window, the item and beat layouts and the
// erase sequencer phases.
// ----------------------------------------------------------------------------
package cle_pkg;

  localparam int unsigned MAX_COUNT = 4096;

  localparam logic [31:0] SDRAM_LOW  = 32'ha000_0000;
  localparam logic [31:0] SDRAM_HIGH = 32'ha3ff_ffff;

  localparam logic [7:0] CH_EOT   = 8'd4;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_DEL   = 8'd127;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_BYTE  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BADFD = 2'd1;
  localparam logic [1:0] ST_FAULT = 2'd2;

  // Erase sends three beats; the other commands use only the first phase.
  typedef enum logic [2:0] {
    PH_FIRST = 3'b001,
    PH_SPACE = 3'b010,
    PH_BS    = 3'b100
  } phase_t;

  typedef struct packed {
    logic        command;
    logic [7:0]  fd_number;
    logic [31:0] buffer_address;
    logic [12:0] byte_count;
    logic [7:0]  rx_byte;
  } item_t;

  typedef struct packed {
    logic        echo_valid;
    logic [7:0]  echo_char;
    logic        store_valid;
    logic [11:0] store_index;
    logic [7:0]  store_data;
    logic        done_res;
    logic [12:0] result_length;
    logic [1:0]  status;
    logic        last;
  } beat_t;

  typedef struct packed {
    logic        active;
    logic [12:0] line_length;
    logic [12:0] length_limit;
  } line_state_t;

endpackage

### rtl/cle_in_if.sv
// ----------------------------------------------------------------------------
// cle_in_if: command channel of the console line editor
// Valid/ready channel carrying start commands and received bytes.
// ----------------------------------------------------------------------------
interface cle_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  fd_number;
  logic [31:0] buffer_address;
  logic [12:0] byte_count;
  logic [7:0]  rx_byte;

  modport source (output valid, command, fd_number, buffer_address, byte_count,
                  rx_byte, input ready);
  modport sink (input valid, command, fd_number, buffer_address, byte_count,
                rx_byte, output ready);
endinterface

### rtl/cle_out_if.sv
// ----------------------------------------------------------------------------
// cle_out_if: result channel of the console line editor
// Valid/ready channel carrying echo, store and completion beats.
// ----------------------------------------------------------------------------
interface cle_out_if;
  logic        valid;
  logic        ready;
  logic        echo_valid;
  logic [7:0]  echo_char;
  logic        store_valid;
  logic [11:0] store_index;
  logic [7:0]  store_data;
  logic        done_res;
  logic [12:0] result_length;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, echo_valid, echo_char, store_valid, store_index,
                  store_data, done_res, result_length, status, last,
                  input ready);
  modport sink (input valid, echo_valid, echo_char, store_valid, store_index,
                store_data, done_res, result_length, status, last,
                output ready);
endinterface

### rtl/cle_edit.sv
// ----------------------------------------------------------------------------
// cle_edit: line editing step
// Decodes one item against the line state for the current phase and returns
// the beat, whether it is the item's final one, and the next line state.
// ----------------------------------------------------------------------------
module cle_edit
  import cle_pkg::*;
(
  input  item_t       item,
  input  phase_t      phase,
  input  line_state_t cur,
  output line_state_t nxt,
  output beat_t       beat,
  output logic        has_beat,
  output logic        final_beat
);

  logic [31:0] end_addr;
  logic        over_max;
  logic [12:0] len_inc;
  logic        is_erase;

  assign end_addr = item.buffer_address + {19'd0, item.byte_count};
  assign over_max = {19'd0, item.byte_count} > 32'(MAX_COUNT);
  assign len_inc  = cur.line_length + 13'd1;
  assign is_erase = (item.rx_byte == CH_BS) || (item.rx_byte == CH_DEL);

  always_comb begin
    nxt        = cur;
    beat       = '0;
    has_beat   = 1'b0;
    final_beat = 1'b1;

    unique case (phase)
      PH_SPACE: begin
        has_beat        = 1'b1;
        final_beat      = 1'b0;
        beat.echo_valid = 1'b1;
        beat.echo_char  = CH_SPACE;
      end
      PH_BS: begin
        has_beat        = 1'b1;
        beat.echo_valid = 1'b1;
        beat.echo_char  = CH_BS;
        beat.last       = 1'b1;
      end
      default: begin
        if (item.command == CMD_START) begin
          nxt       = '0;
          beat.done_res = 1'b1;
          beat.last     = 1'b1;
          priority if (item.fd_number != 8'd0) begin
            has_beat    = 1'b1;
            beat.status = ST_BADFD;
          end else if (!(item.buffer_address >= SDRAM_LOW && end_addr <= SDRAM_HIGH)) begin
            has_beat    = 1'b1;
            beat.status = ST_FAULT;
          end else if (item.byte_count == 13'd0) begin
            has_beat    = 1'b1;
            beat.status = ST_OK;
          end else begin
            nxt.active       = 1'b1;
            nxt.length_limit = over_max ? 13'(MAX_COUNT) : item.byte_count;
          end
        end else if (cur.active) begin
          has_beat = 1'b1;
          priority if (item.rx_byte == CH_EOT) begin
            nxt.active         = 1'b0;
            beat.done_res      = 1'b1;
            beat.result_length = cur.line_length;
            beat.last          = 1'b1;
          end else if (is_erase) begin
            final_beat      = 1'b0;
            beat.echo_valid = 1'b1;
            beat.echo_char  = CH_BS;
            if (cur.line_length != 13'd0) begin
              nxt.line_length  = cur.line_length - 13'd1;
              beat.store_valid = 1'b1;
              beat.store_index = nxt.line_length[11:0];
            end
          end else if (item.rx_byte == CH_LF || item.rx_byte == CH_CR) begin
            nxt.active         = 1'b0;
            nxt.line_length    = len_inc;
            beat.echo_valid    = 1'b1;
            beat.echo_char     = CH_LF;
            beat.store_valid   = 1'b1;
            beat.store_index   = cur.line_length[11:0];
            beat.store_data    = CH_LF;
            beat.done_res      = 1'b1;
            beat.result_length = len_inc;
            beat.last          = 1'b1;
          end else begin
            nxt.line_length  = len_inc;
            beat.echo_valid  = 1'b1;
            beat.echo_char   = item.rx_byte;
            beat.store_valid = 1'b1;
            beat.store_index = cur.line_length[11:0];
            beat.store_data  = item.rx_byte;
            beat.last        = 1'b1;
            if (len_inc >= cur.length_limit) begin
              nxt.active         = 1'b0;
              beat.done_res      = 1'b1;
              beat.result_length = len_inc;
            end
          end
        end
        // a byte while idle drops without a beat
      end
    endcase
  end

endmodule

### rtl/console_line_editor_unit.sv
// ----------------------------------------------------------------------------
// console_line_editor_unit: canonical console line input
// Registered: each item waits in the input register and its beat in the output register.
// One item per cycle while the result channel takes beats; an erase holds its item
//   for three echo beats from one sequencer sharing the output register.
// Reset: rst_n (synchronous, active low) clears both valid flags, the erase
//   phase and the line state; the block comes out idle and takes items at once.
// ----------------------------------------------------------------------------
module console_line_editor_unit
  import cle_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  cle_in_if.sink    in_chan,
  cle_out_if.source out_chan
);

  // Input register: holds one item while the editor works on it.
  logic        ir_valid_r;
  item_t       ir_item_r;

  // Output register: holds one beat until the sink takes it.
  logic        or_valid_r;
  beat_t       or_beat_r;

  // Line state and the erase phase.
  line_state_t line_r;
  phase_t      phase_r;

  line_state_t line_nxt;
  phase_t      phase_nxt;
  beat_t       beat;
  logic        has_beat;
  logic        final_beat;
  logic        out_free;
  logic        fire;
  logic        pop;
  logic        in_take;
  item_t       in_item;

  assign in_item = '{command:        in_chan.command,
                     fd_number:      in_chan.fd_number,
                     buffer_address: in_chan.buffer_address,
                     byte_count:     in_chan.byte_count,
                     rx_byte:        in_chan.rx_byte};

  cle_edit u_edit (
    .item       (ir_item_r),
    .phase      (phase_r),
    .cur        (line_r),
    .nxt        (line_nxt),
    .beat       (beat),
    .has_beat   (has_beat),
    .final_beat (final_beat)
  );

  // The output register is free when empty or drained this cycle.
  assign out_free = !or_valid_r || out_chan.ready;
  // Advance the held item when its beat has room, or when it makes no beat.
  assign fire     = ir_valid_r && (!has_beat || out_free);
  // Drop the item once its final beat (or no beat) has gone out.
  assign pop      = fire && final_beat;

  assign in_chan.ready = !ir_valid_r || pop;
  assign in_take       = in_chan.valid && in_chan.ready;

  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      unique case (phase_r)
        PH_FIRST: phase_nxt = final_beat ? PH_FIRST : PH_SPACE;
        PH_SPACE: phase_nxt = PH_BS;
        PH_BS:    phase_nxt = PH_FIRST;
        default:  phase_nxt = PH_FIRST;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_valid_r <= 1'b0;
      or_valid_r <= 1'b0;
      line_r     <= '0;
      phase_r    <= PH_FIRST;
    end else begin
      // hold the item until popped, refill in the same cycle
      if (in_take) begin
        ir_valid_r <= 1'b1;
      end else if (pop) begin
        ir_valid_r <= 1'b0;
      end
      if (fire && has_beat) begin
        or_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        or_valid_r <= 1'b0;
      end
      // line state moves only on the first phase of an item
      if (fire && phase_r == PH_FIRST) begin
        line_r <= line_nxt;
      end
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      ir_item_r <= in_item;
    end
    if (fire && has_beat) begin
      or_beat_r <= beat;
    end
  end

  assign out_chan.valid         = or_valid_r;
  assign out_chan.echo_valid    = or_beat_r.echo_valid;
  assign out_chan.echo_char     = or_beat_r.echo_char;
  assign out_chan.store_valid   = or_beat_r.store_valid;
  assign out_chan.store_index   = or_beat_r.store_index;
  assign out_chan.store_data    = or_beat_r.store_data;
  assign out_chan.done_res      = or_beat_r.done_res;
  assign out_chan.result_length = or_beat_r.result_length;
  assign out_chan.status        = or_beat_r.status;
  assign out_chan.last          = or_beat_r.last;

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for console_line_editor_unit
// Drives start commands and console bytes on the command channel and predicts
// every echo, store and completion beat with a line-state model kept in this
// file. The model covers descriptor and window checks, erase, terminators and
// the count limit. Each beat taken on the result channel is compared with the
// oldest prediction. Both channels idle at random, and one phase holds the
// result channel off long enough to back the block up onto its input.
// ----------------------------------------------------------------------------
module testbench
  import cle_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEM_TARGET  = 410;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned DRAIN_CYCLES = 12;
  // Worst case is every item's beats meeting the longest sink stalls and source gaps,
  // plus the long hold; take several times that.
  localparam int unsigned CYCLE_LIMIT  = 400_000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  cle_in_if  in_if();
  cle_out_if out_if();

  // Command channel source registers; known from time zero.
  logic  src_valid = 1'b0;
  item_t src_item  = '0;
  // Result channel sink register.
  logic  sink_ready = 1'b0;

  assign in_if.valid          = src_valid;
  assign in_if.command        = src_item.command;
  assign in_if.fd_number      = src_item.fd_number;
  assign in_if.buffer_address = src_item.buffer_address;
  assign in_if.byte_count     = src_item.byte_count;
  assign in_if.rx_byte        = src_item.rx_byte;
  assign out_if.ready         = sink_ready;

  console_line_editor_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always #4 clk = ~clk;

  // Line state of the prediction: open request, bytes collected, length cap.
  bit          line_busy = 1'b0;
  int unsigned line_len  = 0;
  int unsigned line_cap  = 0;

  // Beats still owed by the block, oldest first.
  beat_t pending_beats[$];

  int unsigned mismatches   = 0;
  int unsigned items_sent   = 0;
  int unsigned cycle_count  = 0;
  bit          src_idle_en  = 1'b1;
  bit          sink_idle_en = 1'b1;
  // The sender asks for a long hold-off by bumping hold_asked; the sink
  // process serves it and bumps hold_served.
  int unsigned hold_asked   = 0;
  int unsigned hold_served  = 0;
  int unsigned stall_left   = 0;

  beat_t got_beat;
  beat_t want_beat;

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 15) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  // Fields that are not meaningful are zero in every beat.
  function automatic beat_t mk_beat(input bit echo, input logic [7:0] ch,
                                    input bit store, input int unsigned idx,
                                    input logic [7:0] data, input bit done,
                                    input int unsigned len, input logic [1:0] st,
                                    input bit fin);
    beat_t b;
    b = '0;
    if (echo) begin
      b.echo_valid = 1'b1;
      b.echo_char  = ch;
    end
    if (store) begin
      b.store_valid = 1'b1;
      b.store_index = 12'(idx);
      b.store_data  = data;
    end
    if (done) begin
      b.done_res      = 1'b1;
      b.result_length = 13'(len);
      b.status        = st;
    end
    b.last = fin;
    return b;
  endfunction

  // Advance the line state by one accepted item and queue the beats it owes.
  function automatic void edit_line(input item_t it);
    logic [31:0] end_addr;
    int unsigned idx;
    bit          stored;
    bit          done;
    end_addr = it.buffer_address + {19'd0, it.byte_count};
    if (it.command == CMD_START) begin
      // A new start always drops whatever line was open.
      line_busy = 1'b0;
      line_len  = 0;
      line_cap  = 0;
      if (it.fd_number != 8'd0)
        pending_beats.push_back(mk_beat(0, 0, 0, 0, 0, 1, 0, ST_BADFD, 1));
      else if (!(it.buffer_address >= SDRAM_LOW && end_addr <= SDRAM_HIGH))
        pending_beats.push_back(mk_beat(0, 0, 0, 0, 0, 1, 0, ST_FAULT, 1));
      else if (it.byte_count == 13'd0)
        pending_beats.push_back(mk_beat(0, 0, 0, 0, 0, 1, 0, ST_OK, 1));
      else begin
        line_cap  = (it.byte_count > MAX_COUNT) ? MAX_COUNT : it.byte_count;
        line_busy = 1'b1;
      end
    end else if (line_busy) begin
      if (it.rx_byte == CH_EOT) begin
        line_busy = 1'b0;
        pending_beats.push_back(mk_beat(0, 0, 0, 0, 0, 1, line_len, ST_OK, 1));
      end else if (it.rx_byte == CH_BS || it.rx_byte == CH_DEL) begin
        // Erase echoes three beats even at an empty line; the store rides on
        // the first one.
        stored = 1'b0;
        if (line_len > 0) begin
          line_len--;
          stored = 1'b1;
        end
        pending_beats.push_back(mk_beat(1, CH_BS, stored, line_len, 8'd0, 0, 0, ST_OK, 0));
        pending_beats.push_back(mk_beat(1, CH_SPACE, 0, 0, 0, 0, 0, ST_OK, 0));
        pending_beats.push_back(mk_beat(1, CH_BS, 0, 0, 0, 0, 0, ST_OK, 1));
      end else if (it.rx_byte == CH_LF || it.rx_byte == CH_CR) begin
        idx = line_len;
        line_len++;
        line_busy = 1'b0;
        pending_beats.push_back(mk_beat(1, CH_LF, 1, idx, CH_LF, 1, line_len, ST_OK, 1));
      end else begin
        idx = line_len;
        line_len++;
        done = (line_len >= line_cap);
        if (done) line_busy = 1'b0;
        pending_beats.push_back(mk_beat(1, it.rx_byte, 1, idx, it.rx_byte, done,
                                        line_len, ST_OK, 1));
      end
    end
  endfunction

  // Start commands carry random garbage in the byte field, and byte commands
  // carry it in the start fields, so every input bit toggles.
  function automatic item_t start_item(input logic [7:0] fd, input logic [31:0] addr,
                                       input logic [12:0] cnt);
    item_t it;
    it.command        = CMD_START;
    it.fd_number      = fd;
    it.buffer_address = addr;
    it.byte_count     = cnt;
    it.rx_byte        = 8'($urandom);
    return it;
  endfunction

  function automatic item_t byte_item(input logic [7:0] ch);
    item_t it;
    it.command        = CMD_BYTE;
    it.fd_number      = 8'($urandom);
    it.buffer_address = $urandom;
    it.byte_count     = 13'($urandom);
    it.rx_byte        = ch;
    return it;
  endfunction

  // Offer one item, hold it until taken, then predict and maybe idle.
  // Valid is left high when no gap follows, so back-to-back items never
  // lower and raise it in the same step.
  task automatic send_item(input item_t it);
    int unsigned gap;
    src_item  <= it;
    src_valid <= 1'b1;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    edit_line(it);
    items_sent++;
    if (src_idle_en && $urandom_range(0, 2) == 0) begin
      gap = pick_gap();
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic note_mismatch(input string what, input beat_t want, input beat_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s at cycle %0d", what, cycle_count);
      $display("  want echo %0b/%h store %0b/%0d/%h done %0b len %0d st %0d last %0b",
               want.echo_valid, want.echo_char, want.store_valid, want.store_index,
               want.store_data, want.done_res, want.result_length, want.status,
               want.last);
      $display("  got  echo %0b/%h store %0b/%0d/%h done %0b len %0d st %0d last %0b",
               got.echo_valid, got.echo_char, got.store_valid, got.store_index,
               got.store_data, got.done_res, got.result_length, got.status, got.last);
    end
  endtask

  // Cycle counter and watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d beats outstanding", pending_beats.size());
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Result sink: serve a requested long hold-off first, else stall at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      sink_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      sink_ready <= 1'b0;
    end else if (hold_served != hold_asked) begin
      hold_served++;
      stall_left = HOLD_CYCLES - 1;
      sink_ready <= 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap() - 1;
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // Beat checker: compare every taken beat with the oldest prediction. Both
  // valid and ready are read before this edge's updates land.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      got_beat.echo_valid    = out_if.echo_valid;
      got_beat.echo_char     = out_if.echo_char;
      got_beat.store_valid   = out_if.store_valid;
      got_beat.store_index   = out_if.store_index;
      got_beat.store_data    = out_if.store_data;
      got_beat.done_res      = out_if.done_res;
      got_beat.result_length = out_if.result_length;
      got_beat.status        = out_if.status;
      got_beat.last          = out_if.last;
      if (pending_beats.size() == 0) begin
        note_mismatch("unexpected beat", '0, got_beat);
      end else begin
        want_beat = pending_beats.pop_front();
        if (got_beat !== want_beat) note_mismatch("beat mismatch", want_beat, got_beat);
      end
    end
  end

  // Descriptor and window checks, zero count, address wrap, idle bytes.
  task automatic test_start_checks();
    send_item(start_item(8'hff, SDRAM_LOW, 13'd5));
    send_item(start_item(8'h01, SDRAM_LOW + 32'h40, 13'd1));
    send_item(start_item(8'h00, 32'h9fff_ffff, 13'd1));
    // End lands one past the window top.
    send_item(start_item(8'h00, 32'ha3ff_fff0, 13'h10));
    // End wraps past 2^32 and lands low: passes the window check.
    send_item(start_item(8'h00, 32'hffff_fff0, 13'h20));
    send_item(byte_item(CH_EOT));
    send_item(start_item(8'h00, SDRAM_HIGH, 13'd0));
    // Idle: ignore the byte.
    send_item(byte_item(8'h41));
    // End exactly at the window top.
    send_item(start_item(8'h00, 32'ha3ff_ffef, 13'h10));
    send_item(byte_item(8'h00));
    send_item(byte_item(CH_EOT));
  endtask

  // Erase at empty line, both erase codes, terminators, count reached,
  // oversize count, restart while a line is open.
  task automatic test_line_editing();
    send_item(start_item(8'h00, SDRAM_LOW, 13'd4));
    send_item(byte_item(CH_BS));
    send_item(byte_item(8'h61));
    send_item(byte_item(CH_DEL));
    send_item(byte_item(8'hff));
    send_item(byte_item(CH_LF));
    send_item(start_item(8'h00, SDRAM_LOW + 32'h100, 13'd2));
    send_item(byte_item(8'h80));
    send_item(byte_item(8'h7e));
    send_item(start_item(8'h00, SDRAM_LOW, 13'd8191));
    send_item(byte_item(8'h7a));
    send_item(byte_item(CH_CR));
    send_item(start_item(8'h00, SDRAM_LOW, 13'd4096));
    send_item(byte_item(8'h71));
    send_item(start_item(8'h00, SDRAM_LOW + 32'h2000, 13'd16));
    send_item(byte_item(8'h72));
    send_item(byte_item(CH_EOT));
  endtask

  // Hold the sink off for a long stretch while the sender keeps offering
  // plain bytes of an open line, so the block backs up onto its input.
  task automatic test_backpressure();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    send_item(start_item(8'h00, SDRAM_LOW + 32'h1000, 13'd4096));
    hold_asked++;
    repeat (40) send_item(byte_item(8'($urandom_range(32'h20, 32'h7e))));
    send_item(byte_item(CH_CR));
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) return CH_BS;
    if (r < 18) return CH_DEL;
    if (r < 21) return CH_CR;
    if (r < 24) return CH_LF;
    if (r < 26) return CH_EOT;
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly deep in the window; sometimes right at the top so the end may
  // spill over.
  function automatic logic [31:0] window_addr(input int unsigned cnt);
    if ($urandom_range(0, 7) == 0) return SDRAM_HIGH - cnt + $urandom_range(0, 2);
    return SDRAM_LOW + $urandom_range(0, 32'h03ff_0000);
  endfunction

  task automatic random_line();
    int unsigned r;
    int unsigned cnt;
    int unsigned nbytes;
    r = $urandom_range(0, 99);
    if (r < 75)      cnt = $urandom_range(1, 12);
    else if (r < 92) cnt = $urandom_range(13, 64);
    else if (r < 96) cnt = MAX_COUNT;
    else             cnt = $urandom_range(4097, 8191);
    send_item(start_item(8'h00, window_addr(cnt), 13'(cnt)));
    nbytes = $urandom_range(1, 24);
    for (int i = 0; i < nbytes && line_busy; i++) send_item(byte_item(pick_char()));
    // Now and then poke the idle block with a stray byte.
    if (!line_busy && $urandom_range(0, 9) == 0) send_item(byte_item(pick_char()));
  endtask

  // Well-formed lines with random content, plus failing starts and raw noise.
  task automatic test_random_lines();
    int unsigned r;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 5) == 0) src_idle_en = ~src_idle_en;
      if ($urandom_range(0, 5) == 0) sink_idle_en = ~sink_idle_en;
      r = $urandom_range(0, 99);
      if (r < 80) begin
        random_line();
      end else if (r < 85) begin
        send_item(start_item(8'($urandom_range(1, 255)), $urandom, 13'($urandom)));
      end else if (r < 90) begin
        send_item(start_item(8'h00, $urandom_range(0, 32'h9fff_ffff), 13'($urandom)));
      end else begin
        send_item(($urandom_range(0, 1) == 0) ? byte_item(8'($urandom))
                                               : start_item(8'($urandom), $urandom,
                                                            13'($urandom)));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_start_checks();
    test_line_editing();
    test_backpressure();
    test_random_lines();
    // Drop valid, drain every owed beat, then allow for pipeline latency.
    src_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("%0d mismatches, %0d beats never seen", mismatches, pending_beats.size());
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

### files.f
rtl/cle_pkg.sv
rtl/cle_in_if.sv
rtl/cle_out_if.sv
rtl/cle_edit.sv
rtl/console_line_editor_unit.sv
verif/testbench.sv
